@@ src/bpa_pkg.sv @@
// bitmap page allocator: shared types, codes and helper functions
// no dependencies; used by every module of the allocator
`timescale 1ns / 1ps

package bpa_pkg;

    localparam int MAX_PAGES_DEF = 1024;
    localparam int FUNC_W        = 2;
    localparam int PAGE_NUM_W    = 10;
    localparam int STATUS_W      = 2;
    localparam int COUNT_W       = 11;
    localparam int WORD_W        = 32;
    localparam int BIT_W         = 5;

    localparam logic [FUNC_W-1:0] FN_ALLOC   = 2'd0;
    localparam logic [FUNC_W-1:0] FN_DISPOSE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_CHECK   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    // bitmap word 0 after reset: page zero in use
    localparam logic [WORD_W-1:0] WORD0_RESET = 32'h0000_0001;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [PAGE_NUM_W-1:0] granted;
        logic [COUNT_W-1:0]    count;
        logic [PAGE_NUM_W-1:0] high;
    } bpa_result_t;

    // lowest clear bit of a bitmap word: {found, index}
    function automatic logic [BIT_W:0] first_zero(input logic [WORD_W-1:0] w);
        logic [BIT_W:0] r;
        r = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (!w[i])
            begin
                r = {1'b1, BIT_W'(i)};
            end
        end
        return r;
    endfunction

endpackage

@@ src/bpa_bitmap_mem.sv @@
// bitmap page allocator: used-page bitmap memory, one 32-bit word per row
// registered read; rows past the fill count read as their reset value
// depends on bpa_pkg
`timescale 1ns / 1ps

module bpa_bitmap_mem #(
    parameter int NUM_WORDS = bpa_pkg::MAX_PAGES_DEF / bpa_pkg::WORD_W,
    parameter int ADDR_W    = $clog2(bpa_pkg::MAX_PAGES_DEF / bpa_pkg::WORD_W)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [bpa_pkg::WORD_W-1:0]  rd_data,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [bpa_pkg::WORD_W-1:0]  wr_data
);

    localparam int WORD_W = bpa_pkg::WORD_W;

    logic [WORD_W-1:0] mem [NUM_WORDS];
    logic [WORD_W-1:0] mem_q_reg;
    logic [ADDR_W:0]   fill_reg;
    logic [ADDR_W:0]   fill_next;
    logic              fresh_reg;
    logic              zero_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    // writes never land beyond the fill count, so it grows one row at a time
    always_comb
    begin
        fill_next = fill_reg;
        if (wr_en && ({1'b0, wr_addr} == fill_reg))
        begin
            fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            fresh_reg <= 1'b0;
            zero_reg  <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (rd_en)
            begin
                fresh_reg <= ({1'b0, rd_addr} >= fill_reg);
                zero_reg  <= (rd_addr == '0);
            end
        end
    end

    assign rd_data = fresh_reg ? (zero_reg ? bpa_pkg::WORD0_RESET : '0) : mem_q_reg;

endmodule

@@ src/bpa_ctrl.sv @@
// bitmap page allocator: sequencer for allocate, dispose and check
// scans the bitmap one word per cycle and does read-modify-write
// depends on bpa_pkg
`timescale 1ns / 1ps

module bpa_ctrl #(
    parameter int MAX_PAGES = bpa_pkg::MAX_PAGES_DEF,
    parameter int WADDR_W   = $clog2(bpa_pkg::MAX_PAGES_DEF / bpa_pkg::WORD_W)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [bpa_pkg::FUNC_W-1:0]      func,
    input  logic [bpa_pkg::PAGE_NUM_W-1:0]  page_number,
    output logic                            res_valid,
    input  logic                            res_take,
    output bpa_pkg::bpa_result_t            res,
    output logic                            mem_rd_en,
    output logic [WADDR_W-1:0]              mem_rd_addr,
    input  logic [bpa_pkg::WORD_W-1:0]      mem_rd_data,
    output logic                            mem_wr_en,
    output logic [WADDR_W-1:0]              mem_wr_addr,
    output logic [bpa_pkg::WORD_W-1:0]      mem_wr_data
);

    localparam int BIT_W  = bpa_pkg::BIT_W;
    localparam int WORD_W = bpa_pkg::WORD_W;
    localparam int PN_W   = bpa_pkg::PAGE_NUM_W;
    localparam int CO_W   = bpa_pkg::COUNT_W;
    localparam int FN_W   = bpa_pkg::FUNC_W;
    localparam int PAGE_W = WADDR_W + BIT_W;
    localparam int CNT_W  = $clog2(MAX_PAGES + 1);
    localparam int CMP_W  = (PAGE_W > PN_W) ? PAGE_W : PN_W;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_CHECK  = 4'b0100,
        S_RESULT = 4'b1000
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [PAGE_W-1:0]    hi_reg;
    logic [PAGE_W-1:0]    hi_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic [WADDR_W-1:0]   scan_reg;
    logic [WADDR_W-1:0]   scan_next;
    logic [FN_W-1:0]      func_reg;
    logic [PN_W-1:0]      page_reg;
    bpa_pkg::bpa_result_t res_reg;
    bpa_pkg::bpa_result_t res_next;

    logic [CMP_W-1:0]     in_page_ext;
    logic [CMP_W-1:0]     hi_ext;
    logic [CMP_W-1:0]     page_ext;
    logic [PAGE_W-1:0]    page_idx;
    logic [BIT_W:0]       fz;
    logic [PAGE_W-1:0]    cand;
    logic                 hole;
    logic                 last_word;
    logic [PAGE_W:0]      hi_inc;
    logic                 full;
    logic [PAGE_W-1:0]    new_pg;
    logic                 new_in_word;
    logic [WORD_W-1:0]    hole_mask;
    logic [WORD_W-1:0]    new_mask;
    logic [WORD_W-1:0]    page_mask;

    assign in_page_ext = CMP_W'(page_number);
    assign hi_ext      = CMP_W'(hi_reg);
    assign page_ext    = CMP_W'(page_reg);
    assign page_idx    = page_ext[PAGE_W-1:0];
    assign fz          = bpa_pkg::first_zero(mem_rd_data);
    assign cand        = {scan_reg, fz[BIT_W-1:0]};
    assign hole        = fz[BIT_W] && (cand <= hi_reg);
    assign last_word   = (scan_reg == hi_reg[PAGE_W-1:BIT_W]);
    assign hi_inc      = {1'b0, hi_reg} + 1'b1;
    assign full        = (hi_inc == (PAGE_W + 1)'(MAX_PAGES));
    assign new_pg      = hi_inc[PAGE_W-1:0];
    assign new_in_word = (new_pg[PAGE_W-1:BIT_W] == scan_reg);
    assign hole_mask   = WORD_W'(1) << fz[BIT_W-1:0];
    assign new_mask    = WORD_W'(1) << new_pg[BIT_W-1:0];
    assign page_mask   = WORD_W'(1) << page_idx[BIT_W-1:0];

    always_comb
    begin
        state_next  = state_reg;
        hi_next     = hi_reg;
        cnt_next    = cnt_reg;
        scan_next   = scan_reg;
        res_next    = res_reg;
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = '0;
        mem_wr_data = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_next.status  = bpa_pkg::ST_INVALID;
                    res_next.granted = page_number;
                    res_next.count   = CO_W'(cnt_reg);
                    res_next.high    = PN_W'(hi_reg);
                    case (func)
                        bpa_pkg::FN_ALLOC:
                        begin
                            mem_rd_en  = 1'b1;
                            scan_next  = '0;
                            state_next = S_SCAN;
                        end
                        bpa_pkg::FN_DISPOSE, bpa_pkg::FN_CHECK:
                        begin
                            if (in_page_ext > hi_ext)
                            begin
                                state_next = S_RESULT;
                            end
                            else
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = in_page_ext[PAGE_W-1:BIT_W];
                                state_next  = S_CHECK;
                            end
                        end
                        default:
                        begin
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (hole)
                begin
                    mem_wr_en        = 1'b1;
                    mem_wr_addr      = scan_reg;
                    mem_wr_data      = mem_rd_data | hole_mask;
                    cnt_next         = cnt_reg + 1'b1;
                    res_next.status  = bpa_pkg::ST_OK;
                    res_next.granted = PN_W'(cand);
                    state_next       = S_RESULT;
                end
                else if (last_word)
                begin
                    if (full)
                    begin
                        res_next.status  = bpa_pkg::ST_FULL;
                        res_next.granted = '0;
                    end
                    else
                    begin
                        hi_next   = new_pg;
                        cnt_next  = cnt_reg + 1'b1;
                        mem_wr_en = 1'b1;
                        if (new_in_word)
                        begin
                            mem_wr_addr = scan_reg;
                            mem_wr_data = mem_rd_data | new_mask;
                        end
                        else
                        begin
                            mem_wr_addr = new_pg[PAGE_W-1:BIT_W];
                            mem_wr_data = WORD_W'(1);
                        end
                        res_next.status  = bpa_pkg::ST_OK;
                        res_next.granted = PN_W'(new_pg);
                    end
                    state_next = S_RESULT;
                end
                else
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = scan_reg + 1'b1;
                    scan_next   = scan_reg + 1'b1;
                end
                res_next.count = CO_W'(cnt_next);
                res_next.high  = PN_W'(hi_next);
            end
            S_CHECK:
            begin
                if (mem_rd_data[page_idx[BIT_W-1:0]])
                begin
                    res_next.status = bpa_pkg::ST_OK;
                    if (func_reg == bpa_pkg::FN_DISPOSE)
                    begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = page_idx[PAGE_W-1:BIT_W];
                        mem_wr_data = mem_rd_data & ~page_mask;
                        cnt_next    = cnt_reg - 1'b1;
                    end
                end
                res_next.count = CO_W'(cnt_next);
                state_next     = S_RESULT;
            end
            S_RESULT:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            hi_reg    <= '0;
            cnt_reg   <= CNT_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            hi_reg    <= hi_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        res_reg  <= res_next;
        if (in_valid && in_ready)
        begin
            func_reg <= func;
            page_reg <= page_number;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESULT);
    assign res       = res_reg;

endmodule

@@ src/bitmap_page_allocator.sv @@
// bitmap page allocator: top level with output register and assertions
// depends on bpa_pkg, bpa_bitmap_mem and bpa_ctrl
`timescale 1ns / 1ps

// One operation is in flight at a time. Allocate scans the used-page bitmap
// from page 0, one 32-bit word per cycle, through the word that holds the
// highest page index; dispose and check read the one word that holds the
// page, and a page above the highest index or an unknown function goes
// straight to the result without a bitmap read. The bitmap scan over the
// single-read-port memory sets the allocate time.
// The result sits in an output register, so the next word is taken while the
// previous result waits. No clearing pass is needed after reset: rows beyond
// those written so far read as their reset contents.
module bitmap_page_allocator #(
    parameter int MAX_PAGES = bpa_pkg::MAX_PAGES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [bpa_pkg::FUNC_W-1:0]      func,
    input  logic [bpa_pkg::PAGE_NUM_W-1:0]  page_number,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [bpa_pkg::STATUS_W-1:0]    status,
    output logic [bpa_pkg::PAGE_NUM_W-1:0]  granted_page,
    output logic [bpa_pkg::COUNT_W-1:0]     allocated_count,
    output logic [bpa_pkg::PAGE_NUM_W-1:0]  high_page
);

    localparam int WORD_W    = bpa_pkg::WORD_W;
    localparam int NUM_WORDS = (MAX_PAGES + WORD_W - 1) / WORD_W;
    localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int CO_W      = bpa_pkg::COUNT_W;

    bpa_pkg::bpa_result_t res;
    bpa_pkg::bpa_result_t out_reg;
    logic                 res_valid;
    logic                 res_take;
    logic                 out_valid_reg;
    logic                 mem_rd_en;
    logic [WADDR_W-1:0]   mem_rd_addr;
    logic [WORD_W-1:0]    mem_rd_data;
    logic                 mem_wr_en;
    logic [WADDR_W-1:0]   mem_wr_addr;
    logic [WORD_W-1:0]    mem_wr_data;

    bpa_ctrl #(
        .MAX_PAGES (MAX_PAGES),
        .WADDR_W   (WADDR_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .page_number (page_number),
        .res_valid   (res_valid),
        .res_take    (res_take),
        .res         (res),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data)
    );

    bpa_bitmap_mem #(
        .NUM_WORDS (NUM_WORDS),
        .ADDR_W    (WADDR_W)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    assign res_take = res_valid && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_reg.status;
    assign granted_page    = out_reg.granted;
    assign allocated_count = out_reg.count;
    assign high_page       = out_reg.high;

`ifndef SYNTHESIS
    a_no_same_row: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_rd_en && mem_wr_en) |-> (mem_rd_addr != mem_wr_addr))
        else $error("bitmap read and write hit the same row");

    a_full_means_all_used: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == bpa_pkg::ST_FULL))
            |-> ((granted_page == '0) && (allocated_count == CO_W'(MAX_PAGES))))
        else $error("full status with pages still free");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second word taken while one is in flight");
`endif

endmodule
